### hw/rtl/awps_pkg.sv
// ----------------------------------------------------------------------------
// awps_pkg
// Shared types and constants for the aligned word pattern scan.
// ----------------------------------------------------------------------------
package awps_pkg;

   // Window of pattern words compared in parallel (2..4)
   localparam int PATTERN_WORDS = 4;
   localparam int WIN_DEPTH     = PATTERN_WORDS - 1;

   localparam int WORD_W   = 32;
   localparam int IDX_W    = 19;
   localparam int CNT_W    = 16;
   localparam int OFS_W    = 21;
   localparam int SHIFT_W  = 20;
   localparam int LEN_W    = 3;
   localparam int PAIR_W   = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_WORDS);

   // Queue between the classifier and the result stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW_PAIR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH_PAIR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MATCHES       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_WORDS      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PATCH_SHIFT       = 3'd5;

   typedef struct packed {
      logic [PAIR_W-1:0]  pattern_low_pair;
      logic [PAIR_W-1:0]  pattern_high_pair;
      logic [LEN_W-1:0]   pattern_length;
      logic [CNT_W-1:0]   max_matches;
      logic [IDX_W-1:0]   search_words;
      logic [SHIFT_W-1:0] patch_shift;
   } cfg_type;

   // One match as handed from front to back
   typedef struct packed {
      logic [IDX_W-1:0] start;
      logic [CNT_W-1:0] number;
   } match_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

### hw/rtl/aligned_word_pattern_scan.sv
// ----------------------------------------------------------------------------
// aligned_word_pattern_scan
// Scans a word stream for a configured pattern of up to four words and
// reports byte offset and ordinal of each accepted match.
// ----------------------------------------------------------------------------
//  channel   ports                                   accepted when
//  req       req_push/req_full, data_word, first     push & !full
//  rsp       rsp_pop/rsp_empty, byte_offset, number  pop & !empty
//  csr       csr_valid/csr_ready, index, wdata        valid & ready
//
//  One word per cycle while req_full is low; the window compare, range checks
//  and count update for a word are done in the front in the cycle it is accepted.
//  A match is written into the queue at the edge that accepts its word and moves
//  on to the output register once that register is empty or being popped.
//  req_full rises only when two matches wait in the queue behind a stalled
//  output register.
//  Synchronous active-high reset; configuration returns to its reset values.
// ----------------------------------------------------------------------------
module aligned_word_pattern_scan import awps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [WORD_W-1:0]     req_data_word,
   input  logic                  req_first_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [OFS_W-1:0]      rsp_match_byte_offset,
   output logic [CNT_W-1:0]      rsp_match_number,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PAIR_W-1:0]     csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             q_push, q_pop;
   match_type        q_entry, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_LOW_PAIR:  cfg_in.pattern_low_pair  = csr_wdata;
            CSR_PATTERN_HIGH_PAIR: cfg_in.pattern_high_pair = csr_wdata;
            CSR_PATTERN_LENGTH:    cfg_in.pattern_length    = csr_wdata[LEN_W-1:0];
            CSR_MAX_MATCHES:       cfg_in.max_matches       = csr_wdata[CNT_W-1:0];
            CSR_SEARCH_WORDS:      cfg_in.search_words      = csr_wdata[IDX_W-1:0];
            CSR_PATCH_SHIFT:       cfg_in.patch_shift       = csr_wdata[SHIFT_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low_pair  <= '0;
         cfg_ff.pattern_high_pair <= '0;
         cfg_ff.pattern_length    <= LEN_W'(1);
         cfg_ff.max_matches       <= CNT_W'(1);
         cfg_ff.search_words      <= IDX_W'(1);
         cfg_ff.patch_shift       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   awps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_word  (req_data_word),
      .req_first_word (req_first_word),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   awps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   awps_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .q_status              (q_status),
      .q_head                (q_head),
      .q_pop                 (q_pop),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_match_byte_offset (rsp_match_byte_offset),
      .rsp_match_number      (rsp_match_number)
   );

endmodule

### hw/rtl/awps_front.sv
// ----------------------------------------------------------------------------
// awps_front
// Accepts words, keeps the window, index and match count, and classifies
// each word combinationally as the last word of a match.
// ----------------------------------------------------------------------------
module awps_front import awps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [WORD_W-1:0]     req_data_word,
   input  logic                  req_first_word,
   input  queue_status_type      q_status,
   output logic                  q_push,
   output match_type             q_entry
);

   logic [WORD_W-1:0] window_ff [WIN_DEPTH];
   logic [WORD_W-1:0] window_in [WIN_DEPTH];
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              accept;
   logic [LEN_W-1:0]  len;
   logic [IDX_W-1:0]  w;
   logic [CNT_W-1:0]  mcount;
   logic [IDX_W-1:0]  start;
   logic [WORD_W-1:0] pat [4];
   logic [WORD_W-1:0] have [PATTERN_WORDS];
   logic              words_eq;
   logic              hit;

   assign req_full = q_status.full;
   assign accept   = req_push & ~q_status.full;

   assign pat[0] = cfg.pattern_low_pair[31:0];
   assign pat[1] = cfg.pattern_low_pair[63:32];
   assign pat[2] = cfg.pattern_high_pair[31:0];
   assign pat[3] = cfg.pattern_high_pair[63:32];

   always_comb begin
      len    = (cfg.pattern_length > LEN_MAX) ? LEN_MAX : cfg.pattern_length;
      w      = req_first_word ? '0 : index_ff;
      mcount = req_first_word ? '0 : count_ff;
      start  = w - IDX_W'(len - LEN_W'(1));

      // have[k] lines up with pattern word k; the newest word is pattern word len-1
      words_eq = 1'b1;
      for (int k = 0; k < PATTERN_WORDS; k++) begin
         have[k] = req_data_word;
         for (int j = 0; j < WIN_DEPTH; j++) begin
            if (j + k + 2 == int'(len)) begin
               have[k] = window_ff[j];
            end
         end
         if (k < int'(len) && have[k] != pat[k]) begin
            words_eq = 1'b0;
         end
      end

      hit = (len != '0) && (w != IDX_MAX) && (w >= IDX_W'(len - LEN_W'(1)))
            && (start < cfg.search_words) && (mcount < cfg.max_matches) && words_eq;

      index_in = (w != IDX_MAX) ? w + IDX_W'(1) : w;
      count_in = hit ? mcount + CNT_W'(1) : mcount;

      window_in[0] = req_data_word;
      for (int i = 1; i < WIN_DEPTH; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   assign q_push         = accept & hit;
   assign q_entry.start  = start;
   assign q_entry.number = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < WIN_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
      end else if (accept) begin
         index_ff <= index_in;
         count_ff <= count_in;
         for (int i = 0; i < WIN_DEPTH; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

endmodule

### hw/rtl/awps_queue.sv
// ----------------------------------------------------------------------------
// awps_queue
// Short FIFO of pending matches between front and back.
// ----------------------------------------------------------------------------
module awps_queue import awps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  match_type        push_entry,
   input  logic             pop,
   output match_type        head,
   output queue_status_type status
);

   match_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push & ~status.full;
   assign do_pop  = pop & status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/awps_back.sv
// ----------------------------------------------------------------------------
// awps_back
// Turns a queued match into its byte offset and holds it in the output
// register until the consumer takes it.
// ----------------------------------------------------------------------------
module awps_back import awps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  queue_status_type   q_status,
   input  match_type          q_head,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [OFS_W-1:0]   rsp_match_byte_offset,
   output logic [CNT_W-1:0]   rsp_match_number
);

   logic               valid_ff, valid_in;
   logic [OFS_W-1:0]   offset_ff, offset_in;
   logic [CNT_W-1:0]   number_ff;
   logic               load;

   assign load      = q_status.valid & (~valid_ff | rsp_pop);
   assign q_pop     = load;
   assign offset_in = {q_head.start, 2'b00} + OFS_W'(cfg.patch_shift);
   assign valid_in  = load | (valid_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         offset_ff <= offset_in;
         number_ff <= q_head.number;
      end
   end

   assign rsp_empty             = ~valid_ff;
   assign rsp_match_byte_offset = offset_ff;
   assign rsp_match_number      = number_ff;

endmodule

### tb/aligned_word_pattern_scan_test.sv
// ----------------------------------------------------------------------------
// aligned_word_pattern_scan_test
// Streams word scans into the pattern scanner and checks every match report
// against a cycle-free predictor of window compare, limits and offsets.
// ----------------------------------------------------------------------------
module aligned_word_pattern_scan_test import awps_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [OFS_W-1:0] offset;
      logic [CNT_W-1:0] number;
   } match_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [WORD_W-1:0]    req_data_word = '0;
   logic                 req_first_word = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [OFS_W-1:0]     rsp_match_byte_offset;
   logic [CNT_W-1:0]     rsp_match_number;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PATTERN_LOW_PAIR;
   logic [PAIR_W-1:0]    csr_wdata = '0;

   aligned_word_pattern_scan dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_data_word         (req_data_word),
      .req_first_word        (req_first_word),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_match_byte_offset (rsp_match_byte_offset),
      .rsp_match_number      (rsp_match_number),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   // flow-control mix, percent of cycles spent idle
   int unsigned req_idle_pct = 14;
   int unsigned rsp_idle_pct = 78;

   // predictor copy of the registers and scan state
   logic [PAIR_W-1:0]  cur_pat_lo;
   logic [PAIR_W-1:0]  cur_pat_hi;
   logic [LEN_W-1:0]   cur_len;
   logic [CNT_W-1:0]   cur_limit;
   logic [IDX_W-1:0]   cur_span;
   logic [SHIFT_W-1:0] cur_shift;
   logic [WORD_W-1:0]  history [WIN_DEPTH];
   logic [IDX_W-1:0]   scan_pos;
   logic [CNT_W-1:0]   scan_hits;

   match_report_type awaited_matches [$];

   // stimulus-side view of the pattern in force
   logic [WORD_W-1:0] stim_pat [4];
   int unsigned       stim_len;

   int unsigned words_sent;
   int unsigned marks_sent;
   int unsigned reports_checked;
   int unsigned reg_writes;
   int unsigned failures;

   function automatic void report_failure(input string what);
      failures++;
      if (failures <= 10)
         $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   function automatic void scan_word(input logic [WORD_W-1:0] word, input logic mark);
      int unsigned       len;
      int unsigned       k;
      logic [IDX_W-1:0]  start;
      logic [WORD_W-1:0] have;
      logic [WORD_W-1:0] want;
      bit                hit;
      match_report_type  rep;
      if (mark) begin
         scan_pos  = '0;
         scan_hits = '0;
      end
      len = (cur_len > PATTERN_WORDS) ? PATTERN_WORDS : cur_len;
      if (len >= 1 && scan_pos != IDX_MAX && scan_pos >= len - 1) begin
         start = scan_pos - IDX_W'(len - 1);
         if (start < cur_span && scan_hits < cur_limit) begin
            hit = 1'b1;
            for (k = 0; k < len; k++) begin
               have = (k == len - 1) ? word : history[len - 2 - k];
               want = (k < 2) ? cur_pat_lo[32*k +: 32] : cur_pat_hi[32*(k-2) +: 32];
               if (have != want)
                  hit = 1'b0;
            end
            if (hit) begin
               scan_hits  = scan_hits + 1'b1;
               rep.offset = OFS_W'({start, 2'b00}) + OFS_W'(cur_shift);
               rep.number = scan_hits;
               awaited_matches.insert(awaited_matches.size(), rep);
            end
         end
      end
      for (k = WIN_DEPTH - 1; k > 0; k--)
         history[k] = history[k-1];
      history[0] = word;
      if (scan_pos != IDX_MAX)
         scan_pos = scan_pos + 1'b1;
   endfunction

   // one process observes all three channels at the clock edge
   always @(posedge clock) begin
      match_report_type exp_rep;
      if (reset) begin
         cur_pat_lo = '0;
         cur_pat_hi = '0;
         cur_len    = LEN_W'(1);
         cur_limit  = CNT_W'(1);
         cur_span   = IDX_W'(1);
         cur_shift  = '0;
         for (int i = 0; i < WIN_DEPTH; i++)
            history[i] = '0;
         scan_pos  = '0;
         scan_hits = '0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            reports_checked++;
            if (awaited_matches.size() == 0) begin
               report_failure($sformatf("unexpected report offset %0h number %0d",
                                        rsp_match_byte_offset, rsp_match_number));
            end else begin
               exp_rep = awaited_matches.pop_front();
               if (rsp_match_byte_offset !== exp_rep.offset)
                  report_failure($sformatf("byte offset expected %0h got %0h",
                                           exp_rep.offset, rsp_match_byte_offset));
               if (rsp_match_number !== exp_rep.number)
                  report_failure($sformatf("match number expected %0d got %0d",
                                           exp_rep.number, rsp_match_number));
            end
         end
         if (csr_valid && csr_ready) begin
            reg_writes++;
            case (csr_index)
               CSR_PATTERN_LOW_PAIR:  cur_pat_lo = csr_wdata;
               CSR_PATTERN_HIGH_PAIR: cur_pat_hi = csr_wdata;
               CSR_PATTERN_LENGTH:    cur_len    = csr_wdata[LEN_W-1:0];
               CSR_MAX_MATCHES:       cur_limit  = csr_wdata[CNT_W-1:0];
               CSR_SEARCH_WORDS:      cur_span   = csr_wdata[IDX_W-1:0];
               CSR_PATCH_SHIFT:       cur_shift  = csr_wdata[SHIFT_W-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            words_sent++;
            if (req_first_word)
               marks_sent++;
            scan_word(req_data_word, req_first_word);
         end
      end
   end

   always @(posedge clock)
      rsp_pop <= ($urandom_range(99) >= rsp_idle_pct);

   // push stays high across back-to-back beats; it drops only for an idle gap
   task automatic send_word(input logic [WORD_W-1:0] word, input logic mark);
      while ($urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_data_word  <= word;
      req_first_word <= mark;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // wait until every expected report is out, plus the pipeline depth
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (awaited_matches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // junk puts random bits above each narrow register's width
   task automatic load_settings(input logic [PAIR_W-1:0] lo, input logic [PAIR_W-1:0] hi,
                                input logic [LEN_W-1:0] len, input logic [CNT_W-1:0] limit,
                                input logic [IDX_W-1:0] span,
                                input logic [SHIFT_W-1:0] shift, input bit junk);
      logic [PAIR_W-1:0] fill;
      fill = junk ? {$urandom, $urandom} : '0;
      write_reg(CSR_PATTERN_LOW_PAIR, lo);
      write_reg(CSR_PATTERN_HIGH_PAIR, hi);
      write_reg(CSR_PATTERN_LENGTH, {fill[PAIR_W-1:LEN_W], len});
      write_reg(CSR_MAX_MATCHES, {fill[PAIR_W-1:CNT_W], limit});
      write_reg(CSR_SEARCH_WORDS, {fill[PAIR_W-1:IDX_W], span});
      write_reg(CSR_PATCH_SHIFT, {fill[PAIR_W-1:SHIFT_W], shift});
      csr_valid <= 1'b0;
      stim_pat[0] = lo[31:0];
      stim_pat[1] = lo[63:32];
      stim_pat[2] = hi[31:0];
      stim_pat[3] = hi[63:32];
      stim_len = (len == 0) ? 1 : (len > 4) ? 4 : len;
   endtask

   // reset values: pattern word zero, one word, one match, one start position
   task automatic check_reset_values();
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0005, 1'b1);
      drain();
   endtask

   task automatic check_pattern_lengths();
      drain();
      load_settings({32'h0000_0000, 32'hFFFF_FFFF}, {32'h7FFF_FFFE, 32'h8000_0001},
                    3'd4, 16'hFFFF, 19'd262144, 20'd0, 1'b0);
      // tail of the pattern straddles a scan mark: too few words, no report
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h8000_0001, 1'b0);
      send_word(32'h7FFF_FFFE, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h8000_0001, 1'b0);
      send_word(32'h7FFF_FFFE, 1'b0);
      drain();
      load_settings({32'h0000_0000, 32'hFFFF_FFFF}, {32'h7FFF_FFFE, 32'h8000_0001},
                    3'd0, 16'hFFFF, 19'd262144, 20'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      drain();
      // length above four is clamped and compares the full window plus the new word
      load_settings({32'h0000_0000, 32'hFFFF_FFFF}, {32'h7FFF_FFFE, 32'h8000_0001},
                    3'd7, 16'hFFFF, 19'd262144, 20'hFFFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h8000_0001, 1'b0);
      send_word(32'h7FFF_FFFE, 1'b0);
      drain();
   endtask

   task automatic check_limits();
      drain();
      load_settings(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    3'd1, 16'd0, 19'd262144, 20'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      drain();
      load_settings(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    3'd1, 16'hFFFF, 19'd0, 20'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      drain();
      load_settings(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    3'd2, 16'd2, 19'd4, 20'd3, 1'b0);
      repeat (6) send_word(32'hFFFF_FFFF, 1'b0);
      drain();
   endtask

   task automatic check_random_scans(input int unsigned n_items);
      int unsigned       stop_at;
      int unsigned       half_at;
      int unsigned       r;
      int unsigned       cnt;
      int unsigned       k;
      bit                paused;
      logic              mark;
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] pw [4];
      logic [LEN_W-1:0]  len;
      logic [CNT_W-1:0]  limit;
      logic [IDX_W-1:0]  span;
      logic [SHIFT_W-1:0] shift;
      drain();
      base = $urandom;
      for (k = 0; k < 4; k++) begin
         r = $urandom_range(99);
         pw[k] = (r < 30) ? base : (r < 38) ? '0 : (r < 46) ? '1 : $urandom;
      end
      r = $urandom_range(99);
      len = (r < 8) ? 3'd0 : (r < 18) ? LEN_W'($urandom_range(5, 7))
                                      : LEN_W'($urandom_range(1, 4));
      r = $urandom_range(99);
      limit = (r < 5) ? 16'd0 : (r < 20) ? 16'hFFFF : CNT_W'($urandom_range(1, 8));
      r = $urandom_range(99);
      span = (r < 5) ? 19'd0 : (r < 20) ? 19'd262144 : IDX_W'($urandom_range(1, 40));
      r = $urandom_range(99);
      shift = (r < 15) ? 20'd0 : (r < 30) ? 20'hFFFFF : SHIFT_W'($urandom);
      load_settings({pw[1], pw[0]}, {pw[3], pw[2]}, len, limit, span, shift,
                    $urandom_range(1));

      stop_at = words_sent + n_items;
      half_at = words_sent + n_items / 2;
      paused  = 1'b0;
      while (words_sent < stop_at) begin
         // most scans start with a mark; some just continue the previous one
         mark = ($urandom_range(99) < 85);
         repeat ($urandom_range(1, 8)) begin
            r = $urandom_range(99);
            if (r < 60) begin
               cnt = (r < 45) ? stim_len : $urandom_range(1, stim_len);
               for (k = 0; k < cnt; k++) begin
                  send_word(stim_pat[k], mark);
                  mark = 1'b0;
               end
            end else begin
               send_word((r < 80) ? stim_pat[$urandom_range(0, 3)] : $urandom, mark);
               mark = 1'b0;
            end
         end
         if (!paused && words_sent >= half_at) begin
            paused = 1'b1;
            drain();
         end
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_reset_values();
      check_pattern_lengths();
      check_limits();
      repeat (4) check_random_scans(100);

      req_idle_pct = 78;
      rsp_idle_pct = 14;
      repeat (4) check_random_scans(100);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (4) check_random_scans(100);

      drain();
      while (awaited_matches.size() != 0) begin
         void'(awaited_matches.pop_front());
         report_failure("expected report never arrived");
      end
      $display("Covered %0d words (%0d scan marks), %0d reports, %0d register writes.",
               words_sent, marks_sent, reports_checked, reg_writes);
      $display("Pattern lengths 0-7, zero and full limits, marks inside a pattern; %0d errors.",
               failures);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/awps_pkg.sv
hw/rtl/awps_front.sv
hw/rtl/awps_queue.sv
hw/rtl/awps_back.sv
hw/rtl/aligned_word_pattern_scan.sv
tb/aligned_word_pattern_scan_test.sv
